// ===== hdl/prd_pkg.sv =====
package prd_pkg;

  // field and datapath widths
  localparam int VW   = 24;  // config vector components, Q8.16
  localparam int TNW  = 20;  // tangent of half fov, Q4.16
  localparam int PXW  = 10;  // pixel coordinates
  localparam int QW   = 18;  // unit vector components, Q1.16
  localparam int QB   = 17;  // quotient bits of a unit component magnitude
  localparam int NW   = 14;  // signed pixel offset from the image center, doubled
  localparam int FW   = 32;  // forward times image height
  localparam int TW   = 38;  // basis vector times tangent
  localparam int CW   = 43;  // cross product at scale 2^32
  localparam int DW   = 52;  // unnormalized ray direction
  localparam int MW   = 30;  // scaled magnitude, top bit in [29]
  localparam int RW   = 31;  // integer square root
  localparam int SW   = 64;  // sum of squares and root remainder
  localparam int NUMW = 48;  // divider remainder

  typedef enum logic [2:0] {
    REG_VIEW_X = 3'd0,
    REG_VIEW_Y = 3'd1,
    REG_VIEW_Z = 3'd2,
    REG_UP_X   = 3'd3,
    REG_UP_Y   = 3'd4,
    REG_UP_Z   = 3'd5,
    REG_TAN    = 3'd6
  } reg_idx_e;

  localparam logic signed [VW-1:0]  RST_VIEW_X = 24'sd0;
  localparam logic signed [VW-1:0]  RST_VIEW_Y = -24'sd196608;
  localparam logic signed [VW-1:0]  RST_VIEW_Z = -24'sd262144;
  localparam logic signed [VW-1:0]  RST_UP_X   = 24'sd0;
  localparam logic signed [VW-1:0]  RST_UP_Y   = 24'sd65536;
  localparam logic signed [VW-1:0]  RST_UP_Z   = 24'sd0;
  localparam logic [TNW-1:0]        RST_TAN    = 20'd37837;

endpackage

// ===== hdl/prd_norm.sv =====
module prd_norm #(
  parameter int W = 52
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             flush_i,
  input  logic                             valid_i,
  input  logic signed [W-1:0]              vec_i [3],
  output logic                             valid_o,
  output logic signed [prd_pkg::QW-1:0]    q_o [3],
  output logic                             zero_o
);

  localparam int MW   = prd_pkg::MW;
  localparam int RW   = prd_pkg::RW;
  localparam int SW   = prd_pkg::SW;
  localparam int QB   = prd_pkg::QB;
  localparam int QW   = prd_pkg::QW;
  localparam int NUMW = prd_pkg::NUMW;
  localparam int NC   = (W + 7) / 8;
  localparam int PB   = NC * 8;
  localparam int PWW  = $clog2(PB);
  localparam int HI   = MW - 1;

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         neg;
    logic               zero;
  } car_t;

  // stage 1: magnitudes
  logic [W-1:0]    mag1_q [3];
  logic [2:0]      neg1_q;
  logic            v1_q;
  // stage 2: per-byte leading one of the or of the magnitudes
  logic [W-1:0]    mag2_q [3];
  logic [2:0]      neg2_q;
  logic [NC-1:0]   nz2_q;
  logic [2:0]      pos2_q [NC];
  logic            v2_q;
  // stage 3: leading one position
  logic [W-1:0]    mag3_q [3];
  logic [2:0]      neg3_q;
  logic [PWW-1:0]  p3_q;
  logic            zero3_q;
  logic            v3_q;
  // stage 4: scaled magnitudes
  car_t            c4_q;
  logic            v4_q;
  // stage 5: squares
  car_t            c5_q;
  logic [2*MW-1:0] sq5_q [3];
  logic            v5_q;
  // stage 6: sum of squares
  car_t            c6_q;
  logic [SW-1:0]   s6_q;
  logic            v6_q;
  // square root, one bit per stage
  logic [SW-1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  car_t            rc_q   [RW];
  logic            rv_q   [RW];
  // division, one quotient bit per stage
  logic [NUMW-1:0] drem_q [QB][3];
  logic [QB-1:0]   dq_q   [QB][3];
  logic [RW-1:0]   dl_q   [QB];
  car_t            dc_q   [QB];
  logic            dv_q   [QB];

  logic [W-1:0]    mag1_d [3];
  logic [PB-1:0]   orp;
  logic [NC-1:0]   nz2_d;
  logic [2:0]      pos2_d [NC];
  logic [PWW-1:0]  p3_d;
  logic            zero3_d;
  logic [MW-1:0]   m4_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = vec_i[i][W-1] ? W'(-vec_i[i]) : W'(vec_i[i]);
    end
  end

  always_comb begin
    orp = PB'(mag1_q[0] | mag1_q[1] | mag1_q[2]);
    for (int c = 0; c < NC; c++) begin
      nz2_d[c]  = |orp[c*8 +: 8];
      pos2_d[c] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (orp[c*8 + b]) begin
          pos2_d[c] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    p3_d    = '0;
    zero3_d = 1'b1;
    for (int c = 0; c < NC; c++) begin
      if (nz2_q[c]) begin
        p3_d    = PWW'(c * 8) | PWW'(pos2_q[c]);
        zero3_d = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p3_q >= PWW'(HI)) begin
        m4_d[i] = MW'(mag3_q[i] >> (p3_q - PWW'(HI)));
      end else begin
        m4_d[i] = MW'(mag3_q[i] << (PWW'(HI) - p3_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (flush_i) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i]    <= mag1_d[i];
        neg1_q[i]    <= vec_i[i][W-1];
        mag2_q[i]    <= mag1_q[i];
        mag3_q[i]    <= mag2_q[i];
        c4_q.m[i]    <= m4_d[i];
        sq5_q[i]     <= (2*MW)'(c4_q.m[i]) * (2*MW)'(c4_q.m[i]);
      end
      neg2_q  <= neg1_q;
      nz2_q   <= nz2_d;
      pos2_q  <= pos2_d;
      neg3_q  <= neg2_q;
      p3_q    <= p3_d;
      zero3_q <= zero3_d;
      c4_q.neg  <= neg3_q;
      c4_q.zero <= zero3_q;
      c5_q    <= c4_q;
      c6_q    <= c5_q;
      s6_q    <= SW'(sq5_q[0]) + SW'(sq5_q[1]) + SW'(sq5_q[2]);
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int K = RW - 1 - j;
    logic [SW-1:0] rem_in;
    logic [RW-1:0] root_in;
    car_t          c_in;
    logic          v_in;
    logic [SW-1:0] trial;
    logic [SW-1:0] rem_d;
    logic [RW-1:0] root_d;

    if (j == 0) begin : g_first
      assign rem_in  = s6_q;
      assign root_in = '0;
      assign c_in    = c6_q;
      assign v_in    = v6_q;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign c_in    = rc_q[j-1];
      assign v_in    = rv_q[j-1];
    end

    always_comb begin
      trial = (SW'(root_in) << (K + 1)) + (SW'(1) << (2 * K));
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (RW'(1) << K);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[j] <= 1'b0;
      end else if (flush_i) begin
        rv_q[j] <= 1'b0;
      end else if (en_i) begin
        rv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        rc_q[j]   <= c_in;
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [NUMW-1:0] rem_in [3];
    logic [QB-1:0]   q_in   [3];
    logic [RW-1:0]   l_in;
    car_t            c_in;
    logic            v_in;
    logic [NUMW-1:0] den;
    logic [NUMW-1:0] rem_d  [3];
    logic [QB-1:0]   q_d    [3];

    if (j == 0) begin : g_first
      assign l_in = root_q[RW-1];
      assign c_in = rc_q[RW-1];
      assign v_in = rv_q[RW-1];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = (NUMW'(rc_q[RW-1].m[i]) << 16) + NUMW'(root_q[RW-1] >> 1);
          q_in[i]   = '0;
        end
      end
    end else begin : g_next
      assign l_in   = dl_q[j-1];
      assign c_in   = dc_q[j-1];
      assign v_in   = dv_q[j-1];
      assign rem_in = drem_q[j-1];
      assign q_in   = dq_q[j-1];
    end

    always_comb begin
      den = NUMW'(l_in) << K;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= den) begin
          rem_d[i] = rem_in[i] - den;
          q_d[i]   = q_in[i] | (QB'(1) << K);
        end else begin
          rem_d[i] = rem_in[i];
          q_d[i]   = q_in[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (flush_i) begin
        dv_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[j] <= rem_d;
        dq_q[j]   <= q_d;
        dl_q[j]   <= l_in;
        dc_q[j]   <= c_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dc_q[QB-1].zero) begin
        q_o[i] = '0;
      end else if (dc_q[QB-1].neg[i]) begin
        q_o[i] = -QW'(dq_q[QB-1][i]);
      end else begin
        q_o[i] = QW'(dq_q[QB-1][i]);
      end
    end
  end

  assign zero_o  = dc_q[QB-1].zero;
  assign valid_o = dv_q[QB-1];

endmodule

// ===== hdl/pinhole_ray_direction_core.sv =====
// channel    dir  fields (lsb first)                             accepted when
// s_axis     in   tdata: pixel_x[9:0], pixel_y[19:10], 0-pad      tvalid & tready
// m_axis     out  tdata: dir_x, dir_y, dir_z (18b each), 0-pad;   tvalid & tready
//                 tuser: degenerate
// cfg        in   cfg_idx_i selects register, cfg_data_i value    cfg_we_i
//
// one pixel per cycle unless the output stalls; the final normalization uses a
// 31-stage square root and a 17-stage divider.
// after reset and after every config write the camera basis is rebuilt through a
// second normalization pipeline (three vectors); s_axis_tready stays low until
// it is done.
// reset is asynchronous active low; config registers return to their defaults.
// a two-deep output (register plus skid beat) keeps the pipe moving for one
// stalled result; a further stall freezes every stage in place.
module pinhole_ray_direction_core #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // dir_x, dir_y, dir_z
  output logic        m_axis_tuser,   // degenerate
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int VW  = prd_pkg::VW;
  localparam int TNW = prd_pkg::TNW;
  localparam int PXW = prd_pkg::PXW;
  localparam int QW  = prd_pkg::QW;
  localparam int NW  = prd_pkg::NW;
  localparam int FW  = prd_pkg::FW;
  localparam int TW  = prd_pkg::TW;
  localparam int CW  = prd_pkg::CW;
  localparam int DW  = prd_pkg::DW;
  localparam int PW  = 2 * VW + 2;  // up times forward product
  localparam logic signed [NW-1:0] IMG_W = NW'(IMAGE_WIDTH);
  localparam logic signed [NW-1:0] IMG_H = NW'(IMAGE_HEIGHT);

  typedef enum logic [8:0] {
    ST_VIEW    = 9'b000000001,
    ST_UP      = 9'b000000010,
    ST_WAIT_F  = 9'b000000100,
    ST_WAIT_U  = 9'b000001000,
    ST_CROSS   = 9'b000010000,
    ST_ISSUE_C = 9'b000100000,
    ST_WAIT_R  = 9'b001000000,
    ST_SCALE   = 9'b010000000,
    ST_RUN     = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic signed [VW-1:0]  view_q [3];
  logic signed [VW-1:0]  up_q   [3];
  logic [TNW-1:0]        tan_q;

  // camera basis
  logic signed [QW-1:0]  fwd_q [3];
  logic signed [QW-1:0]  cup_q [3];
  logic signed [QW-1:0]  rgt_q [3];
  logic                  fzero_q, uzero_q, rzero_q, basis_ok_q;
  logic signed [PW-1:0]  pa_q [3];
  logic signed [PW-1:0]  pb_q [3];
  logic signed [TW-1:0]  rt_q [3];
  logic signed [TW-1:0]  ct_q [3];
  logic signed [FW-1:0]  fh_q [3];

  logic                  bn_valid_in, bn_valid, bn_zero;
  logic signed [CW-1:0]  bn_vec [3];
  logic signed [QW-1:0]  bn_q   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q[0] <= prd_pkg::RST_VIEW_X;
      view_q[1] <= prd_pkg::RST_VIEW_Y;
      view_q[2] <= prd_pkg::RST_VIEW_Z;
      up_q[0]   <= prd_pkg::RST_UP_X;
      up_q[1]   <= prd_pkg::RST_UP_Y;
      up_q[2]   <= prd_pkg::RST_UP_Z;
      tan_q     <= prd_pkg::RST_TAN;
    end else if (cfg_we_i) begin
      unique case (prd_pkg::reg_idx_e'(cfg_idx_i))
        prd_pkg::REG_VIEW_X: view_q[0] <= cfg_data_i;
        prd_pkg::REG_VIEW_Y: view_q[1] <= cfg_data_i;
        prd_pkg::REG_VIEW_Z: view_q[2] <= cfg_data_i;
        prd_pkg::REG_UP_X:   up_q[0]   <= cfg_data_i;
        prd_pkg::REG_UP_Y:   up_q[1]   <= cfg_data_i;
        prd_pkg::REG_UP_Z:   up_q[2]   <= cfg_data_i;
        prd_pkg::REG_TAN:    tan_q     <= cfg_data_i[TNW-1:0];
        default: ;
      endcase
    end
  end

  // basis sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_VIEW:    state_d = ST_UP;
      ST_UP:      state_d = ST_WAIT_F;
      ST_WAIT_F:  if (bn_valid) state_d = ST_WAIT_U;
      ST_WAIT_U:  if (bn_valid) state_d = ST_CROSS;
      ST_CROSS:   state_d = ST_ISSUE_C;
      ST_ISSUE_C: state_d = ST_WAIT_R;
      ST_WAIT_R:  if (bn_valid) state_d = ST_SCALE;
      ST_SCALE:   state_d = ST_RUN;
      ST_RUN:     state_d = ST_RUN;
      default:    state_d = ST_VIEW;
    endcase
    if (cfg_we_i) state_d = ST_VIEW;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_VIEW;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    bn_valid_in = 1'b0;
    for (int i = 0; i < 3; i++) begin
      bn_vec[i] = CW'(pa_q[i]) - CW'(pb_q[i]);
    end
    unique case (state_q)
      ST_VIEW: begin
        bn_valid_in = !cfg_we_i;
        for (int i = 0; i < 3; i++) bn_vec[i] = CW'(view_q[i]);
      end
      ST_UP: begin
        bn_valid_in = !cfg_we_i;
        for (int i = 0; i < 3; i++) bn_vec[i] = CW'(up_q[i]);
      end
      ST_ISSUE_C: bn_valid_in = !cfg_we_i;
      default: ;
    endcase
  end

  prd_norm #(
    .W(CW)
  ) u_basis_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (1'b1),
    .flush_i (cfg_we_i),
    .valid_i (bn_valid_in),
    .vec_i   (bn_vec),
    .valid_o (bn_valid),
    .q_o     (bn_q),
    .zero_o  (bn_zero)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT_F && bn_valid) begin
      fwd_q   <= bn_q;
      fzero_q <= bn_zero;
    end
    if (state_q == ST_WAIT_U && bn_valid) begin
      cup_q   <= bn_q;
      uzero_q <= bn_zero;
    end
    if (state_q == ST_WAIT_R && bn_valid) begin
      rgt_q   <= bn_q;
      rzero_q <= bn_zero;
    end
    // up x forward, exact at scale 2^32
    pa_q[0] <= PW'(up_q[1]) * PW'(fwd_q[2]);
    pb_q[0] <= PW'(up_q[2]) * PW'(fwd_q[1]);
    pa_q[1] <= PW'(up_q[2]) * PW'(fwd_q[0]);
    pb_q[1] <= PW'(up_q[0]) * PW'(fwd_q[2]);
    pa_q[2] <= PW'(up_q[0]) * PW'(fwd_q[1]);
    pb_q[2] <= PW'(up_q[1]) * PW'(fwd_q[0]);
    for (int i = 0; i < 3; i++) begin
      rt_q[i] <= TW'(rgt_q[i]) * TW'($signed({1'b0, tan_q}));
      ct_q[i] <= TW'(cup_q[i]) * TW'($signed({1'b0, tan_q}));
      fh_q[i] <= FW'(fwd_q[i]) * FW'(IMG_H);
    end
    basis_ok_q <= !fzero_q && !uzero_q && !rzero_q;
  end

  // pixel pipeline
  logic                  pipe_en;
  logic                  skid_valid_q;
  logic                  p0_valid_q, p1_valid_q, p2_valid_q;
  logic signed [NW-1:0]  nx0_q, ny0_q;
  logic signed [DW-1:0]  a1_q [3];
  logic signed [DW-1:0]  b1_q [3];
  logic signed [DW-1:0]  d2_q [3];
  logic                  pn_valid, pn_zero;
  logic signed [QW-1:0]  pn_q [3];
  logic [PXW-1:0]        px, py;

  assign pipe_en       = !skid_valid_q;
  assign s_axis_tready = pipe_en && (state_q == ST_RUN);
  assign px            = s_axis_tdata[PXW-1:0];
  assign py            = s_axis_tdata[2*PXW-1:PXW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_valid_q <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      p0_valid_q <= s_axis_tvalid && s_axis_tready;
      p1_valid_q <= p0_valid_q;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      nx0_q <= $signed(NW'({px, 1'b1})) - IMG_W;
      ny0_q <= IMG_H - $signed(NW'({py, 1'b1}));
      for (int i = 0; i < 3; i++) begin
        a1_q[i] <= DW'(rt_q[i]) * DW'(nx0_q);
        b1_q[i] <= DW'(ct_q[i]) * DW'(ny0_q);
        d2_q[i] <= (DW'(fh_q[i]) <<< 16) + a1_q[i] + b1_q[i];
      end
    end
  end

  prd_norm #(
    .W(DW)
  ) u_dir_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .flush_i (1'b0),
    .valid_i (p2_valid_q),
    .vec_i   (d2_q),
    .valid_o (pn_valid),
    .q_o     (pn_q),
    .zero_o  (pn_zero)
  );

  // output register plus skid beat
  logic        push;
  logic        res_zero;
  logic [54:0] res;
  logic [54:0] out_q, skid_q;
  logic        out_valid_q;

  assign push     = pn_valid && pipe_en;
  // any zero-length vector gives a zero direction
  assign res_zero = pn_zero || !basis_ok_q;
  assign res      = res_zero ? {1'b1, 54'd0} : {1'b0, pn_q[2], pn_q[1], pn_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_axis_tready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q[53:0]};
  assign m_axis_tuser  = out_q[54];

endmodule

// ===== sim/tb.sv =====
module tb;

  localparam int IMG_W = 1024;
  localparam int IMG_H = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [2:0] REG_NONE = 3'd7;  // no register behind this index

  typedef longint vec3_t [3];
  typedef struct {
    logic signed [prd_pkg::QW-1:0] dx;
    logic signed [prd_pkg::QW-1:0] dy;
    logic signed [prd_pkg::QW-1:0] dz;
    logic                          degen;
  } ray_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  // camera as the block should hold it
  logic signed [prd_pkg::VW-1:0] cam_view [3];
  logic signed [prd_pkg::VW-1:0] cam_up [3];
  logic [prd_pkg::TNW-1:0]       cam_tan;

  ray_t exp_rays[$];
  int   fail_cnt = 0;
  int   cycle_cnt = 0;
  bit   no_idle = 1'b0;
  bit   hold_req = 1'b0;

  pinhole_ray_direction_core #(
    .IMAGE_WIDTH(IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t timeout, %0d rays outstanding", $time, exp_rays.size());
      $display("tb failed");
      $finish;
    end
  end

  function automatic bit [63:0] isqrt(input bit [63:0] s);
    bit [63:0] r = 0;
    bit [63:0] b = 64'h4000_0000_0000_0000;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale to [2^29, 2^30), then divide by the rounded-down length into Q1.16
  function automatic bit unit_vec(input vec3_t v, output vec3_t o);
    bit [63:0] m [3];
    bit [63:0] mx, s, len, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
      o[i] = 0;
    end
    if (mx == 0) return 1'b0;
    while (mx >= 64'd1 << 30) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < 64'd1 << 29) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    len = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 65536 + len / 2) / len;
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic ray_t predict_ray(input logic [prd_pkg::PXW-1:0] px,
                                       input logic [prd_pkg::PXW-1:0] py);
    vec3_t view, up, fwd, crs, rgt, cup, sum, dir;
    longint nx, ny, tn;
    bit ok;
    ray_t r;
    nx = 2 * longint'(px) + 1 - IMG_W;
    ny = IMG_H - 2 * longint'(py) - 1;
    tn = longint'({44'd0, cam_tan});
    for (int i = 0; i < 3; i++) begin
      view[i] = longint'(cam_view[i]);
      up[i] = longint'(cam_up[i]);
    end
    ok = unit_vec(view, fwd);
    crs[0] = up[1] * fwd[2] - up[2] * fwd[1];
    crs[1] = up[2] * fwd[0] - up[0] * fwd[2];
    crs[2] = up[0] * fwd[1] - up[1] * fwd[0];
    ok = unit_vec(crs, rgt) && ok;
    ok = unit_vec(up, cup) && ok;
    for (int i = 0; i < 3; i++)
      sum[i] = fwd[i] * 65536 * IMG_H + (rgt[i] * nx + cup[i] * ny) * tn;
    ok = unit_vec(sum, dir) && ok;
    r.dx = ok ? dir[0][prd_pkg::QW-1:0] : '0;
    r.dy = ok ? dir[1][prd_pkg::QW-1:0] : '0;
    r.dz = ok ? dir[2][prd_pkg::QW-1:0] : '0;
    r.degen = !ok;
    return r;
  endfunction

  task automatic send_pixel(input logic [prd_pkg::PXW-1:0] px,
                            input logic [prd_pkg::PXW-1:0] py);
    int gap;
    bit rdy;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, py, px};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    exp_rays.push_back(predict_ray(px, py));
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(10'($urandom), 10'($urandom));
  endtask

  // registers change only with nothing in flight
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    wait (exp_rays.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      prd_pkg::REG_VIEW_X: cam_view[0] = data;
      prd_pkg::REG_VIEW_Y: cam_view[1] = data;
      prd_pkg::REG_VIEW_Z: cam_view[2] = data;
      prd_pkg::REG_UP_X:   cam_up[0] = data;
      prd_pkg::REG_UP_Y:   cam_up[1] = data;
      prd_pkg::REG_UP_Z:   cam_up[2] = data;
      prd_pkg::REG_TAN:    cam_tan = data[prd_pkg::TNW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(input logic [23:0] vx, vy, vz, ux, uy, uz, tn);
    wait_drained();
    cfg_write(prd_pkg::REG_VIEW_X, vx);
    cfg_write(prd_pkg::REG_VIEW_Y, vy);
    cfg_write(prd_pkg::REG_VIEW_Z, vz);
    cfg_write(prd_pkg::REG_UP_X, ux);
    cfg_write(prd_pkg::REG_UP_Y, uy);
    cfg_write(prd_pkg::REG_UP_Z, uz);
    cfg_write(prd_pkg::REG_TAN, tn);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [23:0] rand_comp();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return 24'($signed($urandom_range(0, 1 << 13)) - (1 << 12));
      default: return '0;
    endcase
  endfunction

  task automatic test_corner_pixels();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd511, 10'd512);
    send_pixel(10'd512, 10'd511);
    send_pixel(10'h155, 10'h2aa);
    send_pixel(10'h2aa, 10'h155);
  endtask

  task automatic test_degenerate_cameras();
    // zero view vector
    set_camera(24'd0, 24'd0, 24'd0, 24'd0, 24'd65536, 24'd0, 24'd37837);
    send_pixel(10'd3, 10'd700);
    // zero up vector
    set_camera(24'd65536, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd37837);
    send_pixel(10'd900, 10'd2);
    // up parallel to view
    set_camera(24'd0, -24'sd131072, 24'd0, 24'd0, 24'd65536, 24'd0, 24'd37837);
    send_pixel(10'd512, 10'd512);
  endtask

  task automatic test_register_extremes();
    set_camera(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'd1, 24'h7fffff, 24'h0fffff);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    set_camera(24'd1, 24'hffffff, 24'd0, 24'hffffff, 24'd0, 24'd1, 24'd0);
    send_pixel(10'd1023, 10'd0);
    // upper data bits of the tangent write are dropped
    set_camera(24'h800000, 24'd0, 24'd0, 24'd0, 24'h7fffff, 24'h800000, 24'hfabcde);
    send_pixel(10'd0, 10'd1023);
    // a write to the spare index changes nothing
    wait_drained();
    cfg_write(REG_NONE, 24'($urandom));
    cfg_we_i <= 1'b0;
    send_pixel(10'd300, 10'd800);
  endtask

  task automatic test_output_backpressure();
    set_camera(24'd65536, 24'd32768, -24'sd196608, 24'd0, 24'd65536, 24'd0, 24'd65536);
    no_idle = 1'b1;
    hold_req = 1'b1;
    send_random(150);
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 11; ph++) begin
      set_camera(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), 24'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      send_random(100);
    end
    no_idle = 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    ray_t exp_r;
    ray_t got_r;
    int stall;
    bit vld;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        vld = m_axis_tvalid;
        got_r.dx = m_axis_tdata[17:0];
        got_r.dy = m_axis_tdata[35:18];
        got_r.dz = m_axis_tdata[53:36];
        got_r.degen = m_axis_tuser;
        @(posedge clk_i);
      end while (!vld);
      if (exp_rays.size() == 0) begin
        fail_cnt++;
        $display("%0t unexpected beat: expected none, actual %0d %0d %0d deg %0b", $time,
                 got_r.dx, got_r.dy, got_r.dz, got_r.degen);
      end else begin
        exp_r = exp_rays.pop_front();
        if (got_r.dx !== exp_r.dx) begin
          fail_cnt++;
          $display("%0t dir_x: expected %0d actual %0d", $time, exp_r.dx, got_r.dx);
        end
        if (got_r.dy !== exp_r.dy) begin
          fail_cnt++;
          $display("%0t dir_y: expected %0d actual %0d", $time, exp_r.dy, got_r.dy);
        end
        if (got_r.dz !== exp_r.dz) begin
          fail_cnt++;
          $display("%0t dir_z: expected %0d actual %0d", $time, exp_r.dz, got_r.dz);
        end
        if (got_r.degen !== exp_r.degen) begin
          fail_cnt++;
          $display("%0t degenerate: expected %0b actual %0b", $time, exp_r.degen,
                   got_r.degen);
        end
      end
    end
  end

  initial begin
    cam_view[0] = prd_pkg::RST_VIEW_X;
    cam_view[1] = prd_pkg::RST_VIEW_Y;
    cam_view[2] = prd_pkg::RST_VIEW_Z;
    cam_up[0] = prd_pkg::RST_UP_X;
    cam_up[1] = prd_pkg::RST_UP_Y;
    cam_up[2] = prd_pkg::RST_UP_Z;
    cam_tan = prd_pkg::RST_TAN;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_pixels();
    test_degenerate_cameras();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    wait (exp_rays.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
